// ===== rtl/core/uuid_v4_text_generator_top_macros.svh =====
// assertion macros shared by the uuid text generator rtl
// included by the modules that carry concurrent checks
`ifndef UUID_V4_TEXT_GENERATOR_TOP_MACROS_SVH
`define UUID_V4_TEXT_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define UVG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define UVG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/uvg_pkg.sv =====
// types, constants and helper functions for the uuid text generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package uvg_pkg;

  // text layout
  localparam int unsigned UuidLen = 36;
  localparam int unsigned PosW    = 6;
  localparam int unsigned NibW    = 5;
  localparam logic [PosW-1:0] LastPos = 6'd35;
  localparam logic [6:0] AsciiDash = 7'h2d;
  localparam logic [6:0] AsciiFour = 7'h34;

  // 128 random bits produced per seed
  typedef struct packed {
    logic [63:0] r1;
    logic [63:0] r0;
  } rnd_t;

  // queue status seen by producer and consumer
  typedef struct packed {
    logic not_full;
    logic not_empty;
  } q_stat_t;

  // kind of template character at each position
  typedef enum logic [1:0] {
    TMPL_HEX,
    TMPL_Y,
    TMPL_DASH,
    TMPL_FOUR
  } tmpl_kind_e;

  // template "xxxxxxxx-xxxx-4xxx-yxxx-xxxxxxxxxxxx"
  function automatic tmpl_kind_e tmpl_kind(input logic [PosW-1:0] pos);
    tmpl_kind_e kind;
    unique case (pos) inside
      6'd8, 6'd13, 6'd18, 6'd23: kind = TMPL_DASH;
      6'd14:                     kind = TMPL_FOUR;
      6'd19:                     kind = TMPL_Y;
      default:                   kind = TMPL_HEX;
    endcase
    return kind;
  endfunction

  // lowercase hex digit
  function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/uvg_ifs.sv =====
// handshake channels of the uuid text generator: seed in, character out
// no dependencies
`timescale 1ns / 1ps

// seed channel, one item per 128-bit seed
interface uvg_seed_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed_first_word;
  logic [63:0] seed_second_word;

  modport source (output valid, output seed_first_word, output seed_second_word,
                  input ready);
  modport sink   (input valid, input seed_first_word, input seed_second_word,
                  output ready);
endinterface

// character channel, one item per text character
interface uvg_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last_character;

  modport source (output valid, output character, output last_character, input ready);
  modport sink   (input valid, input character, input last_character, output ready);
endinterface

// ===== rtl/core/uvg_front.sv =====
// front end: accepts seeds and runs two xorshift128+ steps into a register
// depends on uvg_pkg and uvg_ifs
`timescale 1ns / 1ps

module uvg_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  uvg_seed_if.sink         seed_i,
  input  uvg_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output uvg_pkg::rnd_t    push_data_o
);
  import uvg_pkg::*;

  logic        valid_q, valid_d;
  rnd_t        rnd_q;
  logic        take;
  logic [63:0] a1, w1, a2, w2;
  rnd_t        rnd_d;

  // two generator steps; the first output word is r0, the second r1
  always_comb begin
    a1 = seed_i.seed_first_word ^ (seed_i.seed_first_word << 23);
    w1 = a1 ^ seed_i.seed_second_word ^ (a1 >> 18) ^ (seed_i.seed_second_word >> 5);
    a2 = seed_i.seed_second_word ^ (seed_i.seed_second_word << 23);
    w2 = a2 ^ w1 ^ (a2 >> 18) ^ (w1 >> 5);
    rnd_d.r0 = w1 + seed_i.seed_second_word;
    rnd_d.r1 = w2 + w1;
  end

  // output register hands over to the queue
  assign push_o       = valid_q & q_stat_i.not_full;
  assign push_data_o  = rnd_q;
  assign seed_i.ready = ~valid_q | q_stat_i.not_full;
  assign take         = seed_i.valid & seed_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rnd_q <= rnd_d;
    end
  end

endmodule

// ===== rtl/core/uvg_fifo.sv =====
// short queue of random words between front and back end
// depends on uvg_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "uuid_v4_text_generator_top_macros.svh"

module uvg_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  uvg_pkg::rnd_t     push_data_i,
  input  logic              pop_i,
  output uvg_pkg::rnd_t     pop_data_o,
  output uvg_pkg::q_stat_t  stat_o
);
  import uvg_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  rnd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.not_full  = (count_q != CntFull);
  assign stat_o.not_empty = (count_q != '0);
  assign pop_data_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // checks
  `UVG_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CntFull, "queue overfilled")
  `UVG_ASSERT_IMP(a_empty_ptrs, clk_i, rst_ni, count_q == '0, rd_ptr_q == wr_ptr_q, "empty ptr mismatch")
  `UVG_ASSERT_NXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + CntW'(1), "push lost")

endmodule

// ===== rtl/core/uvg_back.sv =====
// back end: walks the uuid template and emits one character per item
// depends on uvg_pkg, uvg_ifs and the assertion macro header
`timescale 1ns / 1ps
`include "uuid_v4_text_generator_top_macros.svh"

module uvg_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  uvg_pkg::q_stat_t q_stat_i,
  input  uvg_pkg::rnd_t    rnd_i,
  output logic             pop_o,
  uvg_char_if.source       char_o
);
  import uvg_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [NibW-1:0] k_q, k_d;
  logic            out_valid_q, out_valid_d;
  logic [6:0]      char_q, char_d;
  logic            last_q;
  logic            advance;
  logic            at_last;
  tmpl_kind_e      kind;
  logic [127:0]    rnd_bits;
  logic [3:0]      nib;

  assign rnd_bits = {rnd_i.r1, rnd_i.r0};
  assign nib      = rnd_bits[{k_q, 2'b00} +: 4];
  assign kind     = tmpl_kind(pos_q);
  assign at_last  = (pos_q == LastPos);

  // next character from the template
  always_comb begin
    case (kind)
      TMPL_HEX:  char_d = hex_ascii(nib);
      TMPL_Y:    char_d = hex_ascii({2'b10, nib[1:0]});
      TMPL_DASH: char_d = AsciiDash;
      TMPL_FOUR: char_d = AsciiFour;
      default:   char_d = AsciiDash;
    endcase
  end

  // step through the template whenever the queue holds a word and the output register frees up
  assign advance = q_stat_i.not_empty & (~out_valid_q | char_o.ready);
  assign pop_o   = advance & at_last;

  always_comb begin
    pos_d       = pos_q;
    k_d         = k_q;
    out_valid_d = out_valid_q & ~char_o.ready;
    if (advance) begin
      out_valid_d = 1'b1;
      if (at_last) begin
        pos_d = '0;
        k_d   = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
        if (kind == TMPL_HEX || kind == TMPL_Y) begin
          k_d = k_q + NibW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q <= char_d;
      last_q <= at_last;
    end
  end

  assign char_o.valid          = out_valid_q;
  assign char_o.character      = char_q;
  assign char_o.last_character = last_q;

  // checks; the last position is the 31st random nibble
  `UVG_ASSERT_IMP(a_pos_range, clk_i, rst_ni, 1'b1, pos_q <= LastPos, "position out of range")
  `UVG_ASSERT_IMP(a_start_nib, clk_i, rst_ni, pos_q == '0, k_q == '0, "nibble index not reset")
  `UVG_ASSERT_IMP(a_last_nib, clk_i, rst_ni, at_last, k_q == NibW'(30), "nibble count mismatch")

endmodule

// ===== rtl/core/uuid_v4_text_generator_top.sv =====
// Version-4 UUID text generator. Each seed item (two 64-bit words) runs through two
// xorshift128+ steps in the front end; the 128 random bits wait in a short queue and
// the back end emits the 36 text characters, one per cycle unless the output channel
// stalls, the last flagged. The sustained seed rate is set by the one-character output
// channel; a new seed is taken while the previous text is still going out. With the queue
// empty the first character passes the front-end register, the queue and the output register.
// depends on uvg_pkg, uvg_ifs, uvg_front, uvg_fifo and uvg_back
`timescale 1ns / 1ps

module uuid_v4_text_generator_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  uvg_seed_if.sink    seed_i,
  uvg_char_if.source  char_o
);
  import uvg_pkg::*;

  q_stat_t q_stat;
  rnd_t    push_data;
  rnd_t    pop_data;
  logic    push;
  logic    pop;

  // seed intake and generator
  uvg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  uvg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // character sequencer
  uvg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .rnd_i    (pop_data),
    .pop_o    (pop),
    .char_o   (char_o)
  );

endmodule

// ===== sim/testbench.sv =====
// self-checking bench for the uuid text generator: seeds in, 36 text characters out per seed
// expected text comes from an xorshift128+ predictor of its own; needs uvg_pkg, uvg_ifs and the rtl
`timescale 1ns / 1ps

module testbench;
  import uvg_pkg::*;

  localparam int unsigned DirRows    = 14;
  localparam int unsigned RandItems  = 320;
  localparam int unsigned CalmTail   = 60;
  localparam int unsigned LongHold   = 600;
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned MaxPrinted = 40;
  localparam string UuidTemplate = "xxxxxxxx-xxxx-4xxx-yxxx-xxxxxxxxxxxx";
  localparam string HexDigits    = "0123456789abcdef";
  localparam string ZeroSeedText = "00000000-0000-4000-8000-000000000000";

  // one character of uuid text as the block should send it
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } uuid_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uvg_seed_if seed_if ();
  uvg_char_if char_if ();

  uuid_v4_text_generator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seed_i (seed_if),
    .char_o (char_if)
  );

  uuid_char_t expected_chars[$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  bit         idle_on        = 1'b1;
  bit         long_hold_req  = 1'b0;

  // clock, 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) begin
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // two xorshift128+ steps, result is {second output, first output}
  function automatic logic [127:0] xorshift_pair(input logic [63:0] s0, input logic [63:0] s1);
    logic [63:0] a;
    logic [63:0] n1;
    logic [63:0] n2;
    a  = s0 ^ (s0 << 23);
    n1 = a ^ s1 ^ (a >> 18) ^ (s1 >> 5);
    a  = s1 ^ (s1 << 23);
    n2 = a ^ n1 ^ (a >> 18) ^ (n1 >> 5);
    return {n2 + n1, n1 + s1};
  endfunction

  // queue the 36 characters of one seed; typed text overrides the predictor
  task automatic queue_uuid_text(input logic [63:0] s0, input logic [63:0] s1,
                                 input string typed);
    logic [127:0] rnd;
    logic [3:0]   nib;
    byte          tc;
    int           k;
    uuid_char_t   c;
    rnd = xorshift_pair(s0, s1);
    k   = 0;
    for (int pos = 0; pos < UuidLen; pos++) begin
      tc  = UuidTemplate[pos];
      nib = rnd[4*k +: 4];
      case (tc)
        "x": begin
          tc = HexDigits[nib];
          k++;
        end
        "y": begin
          tc = HexDigits[{2'b10, nib[1:0]}];
          k++;
        end
        default: ;
      endcase
      if (typed.len() != 0) begin
        tc = typed[pos];
      end
      c.code = tc[6:0];
      c.last = (pos == LastPos);
      expected_chars.push_back(c);
    end
  endtask

  // offer one seed, with an optional gap first; returns at the falling edge after acceptance
  task automatic send_seed(input logic [63:0] s0, input logic [63:0] s1, input string typed);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 17);
      seed_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    seed_if.valid            <= 1'b1;
    seed_if.seed_first_word  <= s0;
    seed_if.seed_second_word <= s1;
    do @(posedge clk_i); while (!seed_if.ready);
    queue_uuid_text(s0, s1, typed);
    @(negedge clk_i);
  endtask

  // character receiver: random stall bursts, one long hold on request
  initial begin : char_sink
    int stall;
    char_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        char_if.ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
        char_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else begin
        char_if.ready <= 1'b1;
      end
    end
  end

  // compare every accepted character with the oldest expectation
  always @(posedge clk_i) begin : char_check
    uuid_char_t want;
    if (rst_ni && char_if.valid && char_if.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character %02h with nothing expected", char_if.character));
      end else begin
        want = expected_chars.pop_front();
        if (char_if.character !== want.code) begin
          report_mismatch($sformatf("character %02h, expected %02h",
                                    char_if.character, want.code));
        end
        if (char_if.last_character !== want.last) begin
          report_mismatch($sformatf("last flag %b, expected %b",
                                    char_if.last_character, want.last));
        end
      end
    end
  end

  // stimulus: directed table, then random seeds
  initial begin : stimulus
    logic [63:0] dir_first  [DirRows];
    logic [63:0] dir_second [DirRows];
    string       dir_text   [DirRows];
    logic [63:0] s0;
    logic [63:0] s1;
    int          pick;

    rst_ni                   = 1'b0;
    seed_if.valid            = 1'b0;
    seed_if.seed_first_word  = '0;
    seed_if.seed_second_word = '0;

    dir_first = '{64'h0, '1, '1, 64'h0,
                  64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                  64'h1, 64'h0, 64'h8000_0000_0000_0000, 64'h0,
                  64'h0123_4567_89ab_cdef, 64'h0000_0000_ffff_ffff,
                  64'h0, 64'hdead_beef_cafe_f00d};
    dir_second = '{64'h0, '1, 64'h0, '1,
                   64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                   64'h0, 64'h1, 64'h0, 64'h8000_0000_0000_0000,
                   64'hfedc_ba98_7654_3210, 64'hffff_ffff_0000_0000,
                   64'h0, 64'h0bad_c0de_1234_5678};
    foreach (dir_text[r]) dir_text[r] = "";
    // all-zero seed keeps the generator at zero
    dir_text[0]  = ZeroSeedText;
    dir_text[12] = ZeroSeedText;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      send_seed(dir_first[r], dir_second[r], dir_text[r]);
    end

    // random seeds: calm stretches, one long receiver hold, calm tail
    for (int i = 0; i < RandItems; i++) begin
      idle_on = !((i >= 90 && i < 130) || (i >= 180 && i < 200) ||
                  i >= RandItems - CalmTail);
      if (i == 180) long_hold_req = 1'b1;
      pick = $urandom_range(0, 9);
      s0   = {$urandom, $urandom};
      s1   = {$urandom, $urandom};
      if (pick == 0) begin
        s0 = '0;
      end else if (pick == 1) begin
        s1 = '0;
      end else if (pick == 2) begin
        s0 = 64'd1 << $urandom_range(0, 63);
        s1 = 64'd1 << $urandom_range(0, 63);
      end
      send_seed(s0, s1, "");
    end
    seed_if.valid <= 1'b0;

    // drain, then a short settle
    wait (expected_chars.size() == 0);
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
